// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker of the timer.
// Depends on nothing; included by files that hold concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising clock edge outside reset.
`define CMT_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("timer check failed");

// Implication checked at every rising clock edge outside reset.
`define CMT_ASSERT_IMPL(lbl, clk, rstn, ante, cons) \
  `CMT_ASSERT(lbl, clk, rstn, (ante) |-> (cons))

// Next-cycle implication checked outside reset.
`define CMT_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
  `CMT_ASSERT(lbl, clk, rstn, (ante) |=> (cons))

`endif

// ===== rtl/cmt_pkg.sv =====
// Package of the compare-match timer: widths, register codes, reset values,
// sequencer state type and the divider status struct. Depends on nothing.
`default_nettype none

package cmt_pkg;

  localparam int unsigned DataW       = 64;
  localparam int unsigned FreqW       = 32;
  localparam int unsigned ModeW       = 2;
  localparam int unsigned RegIdxW     = 3;
  localparam int unsigned CtrlW       = 3;
  localparam int unsigned CfgIdxW     = 1;
  localparam int unsigned MulW        = 32;
  // Product of a 64-bit elapsed count and a 32-bit frequency plus a 64-bit
  // remainder stays below 2^97.
  localparam int unsigned DividendW   = 97;
  localparam int unsigned DivSteps    = DividendW;
  localparam int unsigned StepCntW    = $clog2(DivSteps + 1);

  localparam logic [ModeW-1:0] ModeTick  = 2'd0;
  localparam logic [ModeW-1:0] ModeRead  = 2'd1;
  localparam logic [ModeW-1:0] ModeWrite = 2'd2;

  localparam logic [RegIdxW-1:0] RegCtrl    = 3'd0;
  localparam logic [RegIdxW-1:0] RegCount   = 3'd1;
  localparam logic [RegIdxW-1:0] RegCompare = 3'd2;
  localparam logic [RegIdxW-1:0] RegStatus  = 3'd3;
  localparam logic [RegIdxW-1:0] RegFreq    = 3'd4;

  localparam logic [CfgIdxW-1:0] CfgHostFreq = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgVirtFreq = 1'd1;

  localparam int unsigned CtrlEnable   = 0;
  localparam int unsigned CtrlPeriodic = 1;
  localparam int unsigned CtrlIrqEn    = 2;

  localparam logic [DataW-1:0] HostFreqReset = 64'd1000000000;
  localparam logic [FreqW-1:0] VirtFreqReset = 32'd100000000;
  localparam logic [DataW-1:0] CompareReset  = {DataW{1'b1}};

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MUL_LO,
    ST_MUL_HI,
    ST_SUM,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_ADD,
    ST_UPDATE,
    ST_DONE
  } cmt_state_e;

  typedef struct packed {
    logic busy;
    logic done;
  } cmt_div_status_t;

endpackage

`default_nettype wire

// ===== rtl/cmt_if.sv =====
// Valid/ready channel interfaces of the timer: item input, result output and
// configuration write. Depends on cmt_pkg for field widths.
`default_nettype none

interface cmt_in_if;
  logic                              valid;
  logic                              ready;
  logic [cmt_pkg::ModeW-1:0]         mode;
  logic [cmt_pkg::RegIdxW-1:0]       reg_index;
  logic [cmt_pkg::DataW-1:0]         write_data;
  logic [cmt_pkg::DataW-1:0]         cycle_stamp;

  modport source (output valid, mode, reg_index, write_data, cycle_stamp, input ready);
  modport sink   (input valid, mode, reg_index, write_data, cycle_stamp, output ready);
endinterface

interface cmt_out_if;
  logic                      valid;
  logic                      ready;
  logic [cmt_pkg::DataW-1:0] read_data;
  logic                      irq_raised;
  logic                      irq_pending;

  modport source (output valid, read_data, irq_raised, irq_pending, input ready);
  modport sink   (input valid, read_data, irq_raised, irq_pending, output ready);
endinterface

interface cmt_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [cmt_pkg::CfgIdxW-1:0] index;
  logic [cmt_pkg::DataW-1:0]   data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/cmt_div.sv =====
// Serial restoring divider: one quotient bit per cycle of a 97-bit dividend by
// a 64-bit divisor, keeping the low 64 quotient bits. Depends on cmt_pkg.
`default_nettype none

module cmt_div (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             start_i,
  input  wire logic [cmt_pkg::DividendW-1:0]    dividend_i,
  input  wire logic [cmt_pkg::DataW-1:0]        divisor_i,
  output cmt_pkg::cmt_div_status_t              status_o,
  output logic [cmt_pkg::DataW-1:0]             quotient_o,
  output logic [cmt_pkg::DataW-1:0]             remainder_o
);

  logic [cmt_pkg::DividendW-1:0] num_q, num_d;
  logic [cmt_pkg::DataW-1:0]     rem_q, rem_d;
  logic [cmt_pkg::DataW-1:0]     quo_q, quo_d;
  logic [cmt_pkg::StepCntW-1:0]  cnt_q, cnt_d;
  logic                          busy_q, busy_d;
  logic                          done_q, done_d;
  logic [cmt_pkg::DataW:0]       trial;
  logic [cmt_pkg::DataW:0]       diff;
  logic                          fits;
  logic                          last;

  assign trial = {rem_q, num_q[cmt_pkg::DividendW-1]};
  assign diff  = trial - {1'b0, divisor_i};
  assign fits  = ~diff[cmt_pkg::DataW];
  assign last  = (cnt_q == cmt_pkg::StepCntW'(1));

  always_comb begin
    num_d  = num_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = done_q;
    if (start_i) begin
      num_d  = dividend_i;
      rem_d  = '0;
      quo_d  = '0;
      cnt_d  = cmt_pkg::StepCntW'(cmt_pkg::DivSteps);
      busy_d = 1'b1;
      done_d = 1'b0;
    end else if (busy_q) begin
      num_d = {num_q[cmt_pkg::DividendW-2:0], 1'b0};
      rem_d = fits ? diff[cmt_pkg::DataW-1:0] : trial[cmt_pkg::DataW-1:0];
      quo_d = {quo_q[cmt_pkg::DataW-2:0], fits};
      cnt_d = cnt_q - cmt_pkg::StepCntW'(1);
      if (last) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    num_q <= num_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
  end

  assign status_o.busy = busy_q;
  assign status_o.done = done_q;
  assign quotient_o    = quo_q;
  assign remainder_o   = rem_q;

endmodule

`default_nettype wire

// ===== rtl/compare_match_timer_fractional.sv =====
// Compare-match timer with fractional host-to-timer tick conversion.
// Depends on cmt_pkg, the channel interfaces in cmt_if.sv and cmt_div.
`default_nettype none

// The block takes one item at a time and returns one result per item through
// an output register, so a new item is accepted while the previous result
// still waits. A register read or write passes through the EXEC and DONE
// states, and its result is loaded into the output register as DONE is left.
// A tick that converts elapsed host cycles passes through EXEC, MUL_LO, MUL_HI,
// SUM, DIV_GO, DIV_WAIT, ADD, UPDATE and DONE: one shared 32x32 multiplier is
// used twice, and the serial divider produces one quotient bit per cycle and
// flags completion as it registers the last bit. A tick whose quotient is zero
// skips ADD and UPDATE; disabled or zero-elapsed ticks go from EXEC to DONE.
// A result that is not taken holds the following item in its last state.
// Configuration writes are always accepted and take effect at once, so they
// belong between items.
module compare_match_timer_fractional (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cmt_cfg_if.sink    cfg_i,
  cmt_in_if.sink     in_i,
  cmt_out_if.source  out_o
);

  cmt_pkg::cmt_state_e state_q, state_d;

  logic [cmt_pkg::DataW-1:0]   base_freq_q;
  logic [cmt_pkg::FreqW-1:0]   virt_freq_q;
  logic [cmt_pkg::CtrlW-1:0]   ctrl_q;
  logic [cmt_pkg::DataW-1:0]   count_q;
  logic [cmt_pkg::DataW-1:0]   compare_q;
  logic                        irq_q;
  logic [cmt_pkg::DataW-1:0]   tick_rem_q;
  logic [cmt_pkg::DataW-1:0]   last_stamp_q;

  logic [cmt_pkg::ModeW-1:0]   mode_q;
  logic [cmt_pkg::RegIdxW-1:0] reg_index_q;
  logic [cmt_pkg::DataW-1:0]   write_data_q;
  logic [cmt_pkg::DataW-1:0]   cycle_stamp_q;

  logic [cmt_pkg::DataW-1:0]   elapsed_q;
  logic [cmt_pkg::DataW-1:0]   prod_lo_q;
  logic [cmt_pkg::DataW-1:0]   prod_hi_q;
  logic [cmt_pkg::DividendW-1:0] dividend_q;
  logic [cmt_pkg::DataW-1:0]   sum_q;
  logic                        below_q;
  logic [cmt_pkg::DataW-1:0]   rd_q;
  logic                        raised_q;

  logic                        out_valid_q;
  logic [cmt_pkg::DataW-1:0]   out_data_q;
  logic                        out_raised_q;
  logic                        out_pending_q;

  logic                        in_fire;
  logic                        out_free;
  logic                        is_tick;
  logic                        enabled;
  logic [cmt_pkg::DataW-1:0]   elapsed_d;
  logic                        elapsed_zero;
  logic [cmt_pkg::MulW-1:0]    mul_a;
  logic [cmt_pkg::DataW-1:0]   mul_p;
  logic [cmt_pkg::DataW-1:0]   read_mux;
  logic                        hit;
  logic                        div_start;
  logic                        load_result;

  cmt_pkg::cmt_div_status_t    div_status;
  logic [cmt_pkg::DataW-1:0]   div_quotient;
  logic [cmt_pkg::DataW-1:0]   div_remainder;
  logic [cmt_pkg::DataW-1:0]   div_divisor;

  assign cfg_i.ready = 1'b1;
  assign in_i.ready  = (state_q == cmt_pkg::ST_IDLE);
  assign in_fire     = in_i.valid && in_i.ready;
  assign out_free    = !out_valid_q || out_o.ready;

  assign is_tick      = (mode_q == cmt_pkg::ModeTick);
  assign enabled      = ctrl_q[cmt_pkg::CtrlEnable];
  assign elapsed_d    = cycle_stamp_q - last_stamp_q;
  assign elapsed_zero = (elapsed_d == '0);
  assign mul_a        = (state_q == cmt_pkg::ST_MUL_LO) ? elapsed_q[cmt_pkg::MulW-1:0]
                                                        : elapsed_q[cmt_pkg::DataW-1:cmt_pkg::MulW];
  assign mul_p        = cmt_pkg::DataW'(mul_a) * cmt_pkg::DataW'(virt_freq_q);
  assign hit          = below_q && (sum_q >= compare_q);
  assign div_divisor  = (base_freq_q == '0) ? cmt_pkg::DataW'(1) : base_freq_q;

  always_comb begin
    case (reg_index_q)
      cmt_pkg::RegCtrl:    read_mux = cmt_pkg::DataW'(ctrl_q);
      cmt_pkg::RegCount:   read_mux = count_q;
      cmt_pkg::RegCompare: read_mux = compare_q;
      cmt_pkg::RegStatus:  read_mux = cmt_pkg::DataW'(irq_q);
      cmt_pkg::RegFreq:    read_mux = cmt_pkg::DataW'(virt_freq_q);
      default:             read_mux = '0;
    endcase
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      cmt_pkg::ST_IDLE:     if (in_fire) state_d = cmt_pkg::ST_EXEC;
      cmt_pkg::ST_EXEC: begin
        if (is_tick && enabled && !elapsed_zero) state_d = cmt_pkg::ST_MUL_LO;
        else                                     state_d = cmt_pkg::ST_DONE;
      end
      cmt_pkg::ST_MUL_LO:   state_d = cmt_pkg::ST_MUL_HI;
      cmt_pkg::ST_MUL_HI:   state_d = cmt_pkg::ST_SUM;
      cmt_pkg::ST_SUM:      state_d = cmt_pkg::ST_DIV_GO;
      cmt_pkg::ST_DIV_GO:   state_d = cmt_pkg::ST_DIV_WAIT;
      cmt_pkg::ST_DIV_WAIT: begin
        if (div_status.done) begin
          if (div_quotient == '0) state_d = cmt_pkg::ST_DONE;
          else                    state_d = cmt_pkg::ST_ADD;
        end
      end
      cmt_pkg::ST_ADD:      state_d = cmt_pkg::ST_UPDATE;
      cmt_pkg::ST_UPDATE:   state_d = cmt_pkg::ST_DONE;
      cmt_pkg::ST_DONE:     if (out_free) state_d = cmt_pkg::ST_IDLE;
      default:              state_d = cmt_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    div_start   = 1'b0;
    load_result = 1'b0;
    case (state_q)
      cmt_pkg::ST_DIV_GO: div_start   = 1'b1;
      cmt_pkg::ST_DONE:   load_result = out_free;
      default: begin
        div_start   = 1'b0;
        load_result = 1'b0;
      end
    endcase
  end

  cmt_div u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (div_start),
    .dividend_i  (dividend_q),
    .divisor_i   (div_divisor),
    .status_o    (div_status),
    .quotient_o  (div_quotient),
    .remainder_o (div_remainder)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= cmt_pkg::ST_IDLE;
      base_freq_q  <= cmt_pkg::HostFreqReset;
      virt_freq_q  <= cmt_pkg::VirtFreqReset;
      ctrl_q       <= '0;
      count_q      <= '0;
      compare_q    <= cmt_pkg::CompareReset;
      irq_q        <= 1'b0;
      tick_rem_q   <= '0;
      last_stamp_q <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;

      if (cfg_i.valid && cfg_i.ready) begin
        case (cfg_i.index)
          cmt_pkg::CfgHostFreq: base_freq_q <= cfg_i.data;
          cmt_pkg::CfgVirtFreq: virt_freq_q <= cfg_i.data[cmt_pkg::FreqW-1:0];
          default: ;
        endcase
      end

      case (state_q)
        cmt_pkg::ST_EXEC: begin
          if (is_tick) begin
            if (!enabled || !elapsed_zero) last_stamp_q <= cycle_stamp_q;
          end else if (mode_q == cmt_pkg::ModeWrite) begin
            case (reg_index_q)
              cmt_pkg::RegCtrl: begin
                ctrl_q <= write_data_q[cmt_pkg::CtrlW-1:0];
                if (write_data_q[cmt_pkg::CtrlEnable]) last_stamp_q <= cycle_stamp_q;
              end
              cmt_pkg::RegCount:   count_q   <= write_data_q;
              cmt_pkg::RegCompare: compare_q <= write_data_q;
              cmt_pkg::RegStatus:  if (write_data_q[0]) irq_q <= 1'b0;
              default: ;
            endcase
          end
        end
        cmt_pkg::ST_DIV_WAIT: if (div_status.done) tick_rem_q <= div_remainder;
        cmt_pkg::ST_UPDATE: begin
          if (hit) begin
            irq_q <= 1'b1;
            if (ctrl_q[cmt_pkg::CtrlPeriodic]) count_q <= sum_q - compare_q;
            else begin
              count_q                     <= sum_q;
              ctrl_q[cmt_pkg::CtrlEnable] <= 1'b0;
            end
          end else begin
            count_q <= sum_q;
          end
        end
        default: ;
      endcase

      if (load_result)       out_valid_q <= 1'b1;
      else if (out_o.ready)  out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mode_q        <= in_i.mode;
      reg_index_q   <= in_i.reg_index;
      write_data_q  <= in_i.write_data;
      cycle_stamp_q <= in_i.cycle_stamp;
    end
    case (state_q)
      cmt_pkg::ST_EXEC: begin
        elapsed_q <= elapsed_d;
        raised_q  <= 1'b0;
        rd_q      <= (mode_q == cmt_pkg::ModeRead) ? read_mux : '0;
      end
      cmt_pkg::ST_MUL_LO: prod_lo_q <= mul_p;
      cmt_pkg::ST_MUL_HI: prod_hi_q <= mul_p;
      cmt_pkg::ST_SUM: begin
        dividend_q <= cmt_pkg::DividendW'({prod_hi_q, {cmt_pkg::MulW{1'b0}}})
                    + cmt_pkg::DividendW'(prod_lo_q)
                    + cmt_pkg::DividendW'(tick_rem_q);
      end
      cmt_pkg::ST_ADD: begin
        sum_q   <= count_q + div_quotient;
        below_q <= (count_q < compare_q);
      end
      cmt_pkg::ST_UPDATE: raised_q <= hit && ctrl_q[cmt_pkg::CtrlIrqEn];
      default: ;
    endcase
    if (load_result) begin
      out_data_q    <= rd_q;
      out_raised_q  <= raised_q;
      out_pending_q <= irq_q;
    end
  end

  assign out_o.valid       = out_valid_q;
  assign out_o.read_data   = out_data_q;
  assign out_o.irq_raised  = out_raised_q;
  assign out_o.irq_pending = out_pending_q;

endmodule

`default_nettype wire

// ===== rtl/cmt_chk.sv =====
// Port-level checker of the compare-match timer and its bind to the top level.
// Depends on assert_macros.svh and on the top level's channel interfaces.
`default_nettype none

`include "assert_macros.svh"

module cmt_chk (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [63:0] read_data_i,
  input wire logic        irq_raised_i,
  input wire logic        irq_pending_i
);

  logic        out_stall;
  logic        raise_seen;
  logic [65:0] out_payload;

  assign out_stall   = out_valid_i && !out_ready_i;
  assign raise_seen  = out_valid_i && irq_raised_i;
  assign out_payload = {read_data_i, irq_raised_i, irq_pending_i};

  `CMT_ASSERT_NEXT(a_out_valid_holds, clk_i, rst_ni, out_stall, out_valid_i)
  `CMT_ASSERT_NEXT(a_out_payload_holds, clk_i, rst_ni, out_stall, $stable(out_payload))
  `CMT_ASSERT_NEXT(a_one_item_at_a_time, clk_i, rst_ni, in_valid_i && in_ready_i, !in_ready_i)
  `CMT_ASSERT_IMPL(a_raise_implies_pending, clk_i, rst_ni, raise_seen, irq_pending_i)

endmodule

bind compare_match_timer_fractional cmt_chk u_cmt_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .read_data_i   (out_o.read_data),
  .irq_raised_i  (out_o.irq_raised),
  .irq_pending_i (out_o.irq_pending)
);

`default_nettype wire

// ===== bench/cmt_timer_checker.sv =====
// Checker of the compare-match timer: watches the configuration, item and result
// channels, predicts each result from its own copy of the timer state and compares.
// Depends on cmt_pkg and the channel interfaces in cmt_if.sv.
module cmt_timer_checker
  import cmt_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  cmt_cfg_if         cfg_ch,
  cmt_in_if          in_ch,
  cmt_out_if         out_ch,
  output int unsigned mismatch_count,
  output int unsigned pending_count,
  output int unsigned checked_count
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             irq_raised;
    logic             irq_pending;
  } timer_result_t;

  timer_result_t expected_results[$];

  logic [DataW-1:0] base_freq;
  logic [FreqW-1:0] virt_freq;
  logic [CtrlW-1:0] ctrl_bits;
  logic [DataW-1:0] count_value;
  logic [DataW-1:0] compare_value;
  logic             irq_flag;
  logic [DataW-1:0] frac_carry;
  logic [DataW-1:0] last_stamp;

  task automatic report_mismatch(input string field, input logic [DataW-1:0] got,
                                 input logic [DataW-1:0] want);
    $display("[%0t] result %0d: %s is %h, expected %h", $time, checked_count, field, got,
             want);
    mismatch_count++;
  endtask

  task automatic advance_timer(input logic [DataW-1:0] stamp, output logic raised);
    logic [DataW-1:0]   elapsed;
    logic [DataW-1:0]   divisor;
    logic [DataW-1:0]   advance;
    logic [DataW-1:0]   prior_count;
    logic [2*DataW-1:0] dividend;
    logic [2*DataW-1:0] quotient;
    raised = 1'b0;
    if (!ctrl_bits[CtrlEnable]) begin
      last_stamp = stamp;
      return;
    end
    elapsed = stamp - last_stamp;
    last_stamp = stamp;
    if (elapsed == '0) return;
    dividend = {64'd0, elapsed} * {96'd0, virt_freq} + {64'd0, frac_carry};
    divisor = (base_freq == '0) ? 64'd1 : base_freq;
    quotient = dividend / {64'd0, divisor};
    frac_carry = DataW'(dividend % {64'd0, divisor});
    advance = quotient[DataW-1:0];
    if (advance == '0) return;
    prior_count = count_value;
    count_value = count_value + advance;
    if (prior_count < compare_value && count_value >= compare_value) begin
      irq_flag = 1'b1;
      if (ctrl_bits[CtrlPeriodic]) begin
        count_value = count_value - compare_value;
      end else begin
        ctrl_bits[CtrlEnable] = 1'b0;
      end
      raised = ctrl_bits[CtrlIrqEn];
    end
  endtask

  task automatic apply_item(input logic [ModeW-1:0] mode, input logic [RegIdxW-1:0] idx,
                            input logic [DataW-1:0] data, input logic [DataW-1:0] stamp,
                            output timer_result_t res);
    logic raised;
    res = '0;
    case (mode)
      ModeTick: begin
        advance_timer(stamp, raised);
        res.irq_raised = raised;
      end
      ModeRead: begin
        case (idx)
          RegCtrl:    res.read_data = {{(DataW-CtrlW){1'b0}}, ctrl_bits};
          RegCount:   res.read_data = count_value;
          RegCompare: res.read_data = compare_value;
          RegStatus:  res.read_data = {{(DataW-1){1'b0}}, irq_flag};
          RegFreq:    res.read_data = {{(DataW-FreqW){1'b0}}, virt_freq};
          default:    res.read_data = '0;
        endcase
      end
      ModeWrite: begin
        case (idx)
          RegCtrl: begin
            ctrl_bits = data[CtrlW-1:0];
            if (data[CtrlEnable]) last_stamp = stamp;
          end
          RegCount:   count_value = data;
          RegCompare: compare_value = data;
          RegStatus: begin
            if (data[0]) irq_flag = 1'b0;
          end
          default: ;
        endcase
      end
      default: ;
    endcase
    res.irq_pending = irq_flag;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : watch
    timer_result_t res;
    timer_result_t want;
    if (!rst_ni) begin
      base_freq = HostFreqReset;
      virt_freq = VirtFreqReset;
      ctrl_bits = '0;
      count_value = '0;
      compare_value = CompareReset;
      irq_flag = 1'b0;
      frac_carry = '0;
      last_stamp = '0;
      expected_results.delete();
      mismatch_count = 0;
      pending_count = 0;
      checked_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) begin
        if (cfg_ch.index == CfgHostFreq) begin
          base_freq = cfg_ch.data;
        end else begin
          virt_freq = cfg_ch.data[FreqW-1:0];
        end
      end
      if (out_ch.valid && out_ch.ready) begin
        checked_count++;
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result, read_data", out_ch.read_data, '0);
        end else begin
          want = expected_results.pop_front();
          if (out_ch.read_data !== want.read_data)
            report_mismatch("read_data", out_ch.read_data, want.read_data);
          if (out_ch.irq_raised !== want.irq_raised)
            report_mismatch("irq_raised", 64'(out_ch.irq_raised), 64'(want.irq_raised));
          if (out_ch.irq_pending !== want.irq_pending)
            report_mismatch("irq_pending", 64'(out_ch.irq_pending), 64'(want.irq_pending));
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        apply_item(in_ch.mode, in_ch.reg_index, in_ch.write_data, in_ch.cycle_stamp, res);
        expected_results.push_back(res);
      end
      pending_count = expected_results.size();
    end
  end

endmodule

// ===== bench/tb_compare_match_timer_fractional.sv =====
// Testbench top of the compare-match timer: clock, reset, stimulus on the item and
// configuration channels, result back-pressure and the verdict.
// Depends on cmt_pkg, cmt_if.sv, the timer RTL and cmt_timer_checker.
module tb_compare_match_timer_fractional;
  timeunit 1ns;
  timeprecision 1ps;
  import cmt_pkg::*;

  localparam int unsigned CycleLimit = 1000000;
  localparam logic [ModeW-1:0]   ModeNone       = 2'd3;
  localparam logic [RegIdxW-1:0] RegUnusedFirst = 3'd5;
  localparam logic [RegIdxW-1:0] RegUnusedLast  = 3'd7;

  logic clk_i = 1'b0;
  logic rst_ni;

  int unsigned send_idle;
  int unsigned recv_idle;
  int unsigned items_sent;
  int unsigned cycle_count = 0;
  int unsigned mismatch_count;
  int unsigned pending_count;
  int unsigned checked_count;

  logic [DataW-1:0] base_freq_set;
  logic [FreqW-1:0] virt_freq_set;
  logic [DataW-1:0] now_stamp;

  cmt_cfg_if cfg_ch();
  cmt_in_if  in_ch();
  cmt_out_if out_ch();

  compare_match_timer_fractional dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_ch),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  cmt_timer_checker timer_checker (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_ch         (cfg_ch),
    .in_ch          (in_ch),
    .out_ch         (out_ch),
    .mismatch_count (mismatch_count),
    .pending_count  (pending_count),
    .checked_count  (checked_count)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin : result_drain
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      out_ch.ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  function automatic logic [DataW-1:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [DataW-1:0] pick_elapsed();
    logic [2*DataW-1:0] span;
    logic [DataW-1:0]   eff;
    eff = (base_freq_set == '0) ? 64'd1 : base_freq_set;
    case ($urandom_range(9))
      0: span = '0;
      1: span = {64'd0, rand64()};
      default: begin
        span = ({64'd0, eff} * $urandom_range(60) + {64'd0, rand64() % eff}) /
               {96'd0, virt_freq_set};
        if (span == '0) span = 128'd1;
      end
    endcase
    return span[DataW-1:0];
  endfunction

  task automatic push_item(input logic [ModeW-1:0] mode, input logic [RegIdxW-1:0] idx,
                           input logic [DataW-1:0] data, input logic [DataW-1:0] stamp);
    @(negedge clk_i);
    while ($urandom_range(99) < send_idle) begin
      in_ch.valid <= 1'b0;
      @(negedge clk_i);
    end
    in_ch.valid       <= 1'b1;
    in_ch.mode        <= mode;
    in_ch.reg_index   <= idx;
    in_ch.write_data  <= data;
    in_ch.cycle_stamp <= stamp;
    do @(posedge clk_i); while (!in_ch.ready);
    items_sent++;
  endtask

  task automatic write_config(input logic [CfgIdxW-1:0] idx, input logic [DataW-1:0] value);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk_i); while (!cfg_ch.ready);
    @(negedge clk_i);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic settle();
    @(negedge clk_i);
    in_ch.valid <= 1'b0;
    while (pending_count != 0) @(negedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic run_directed();
    push_item(ModeRead, RegCtrl, '0, '0);
    push_item(ModeRead, RegCompare, '0, '0);
    push_item(ModeRead, RegFreq, '0, '0);
    push_item(ModeRead, RegUnusedLast, '0, '0);
    push_item(ModeNone, RegCount, '1, '1);
    push_item(ModeTick, RegCtrl, '0, 64'd1000);
    push_item(ModeWrite, RegCompare, 64'd100, '0);
    push_item(ModeWrite, RegCount, '0, '0);
    push_item(ModeWrite, RegCtrl, '1, 64'd2000);
    push_item(ModeTick, RegCtrl, '0, 64'd2000);
    push_item(ModeTick, RegCtrl, '0, 64'd2005);
    push_item(ModeTick, RegCtrl, '0, 64'd2010);
    push_item(ModeTick, RegCtrl, '0, 64'd3000);
    push_item(ModeRead, RegStatus, '0, '0);
    push_item(ModeWrite, RegStatus, 64'd2, '0);
    push_item(ModeWrite, RegStatus, '1, '0);
    push_item(ModeWrite, RegFreq, 64'd5, '0);
    push_item(ModeWrite, RegUnusedFirst, '1, '1);
    push_item(ModeRead, RegUnusedFirst, '0, '0);
    push_item(ModeWrite, RegCtrl, 64'd5, 64'hFFFF_FFFF_FFFF_FF9C);
    push_item(ModeTick, RegCtrl, '0, 64'd900);
    push_item(ModeRead, RegCtrl, '0, '0);
    push_item(ModeWrite, RegCount, 64'hFFFF_FFFF_FFFF_FFFB, '0);
    push_item(ModeWrite, RegCtrl, 64'd1 << CtrlEnable, '0);
    push_item(ModeTick, RegCtrl, '0, 64'd100);
    push_item(ModeRead, RegCount, '0, '0);
    now_stamp = 64'd100;
  endtask

  task automatic run_sequence();
    logic [DataW-1:0] limit_value;
    logic [DataW-1:0] start_value;
    logic [DataW-1:0] ctrl_value;
    int unsigned      steps;
    limit_value = ($urandom_range(7) == 0) ? rand64() : 64'($urandom_range(1, 300));
    case ($urandom_range(3))
      0: start_value = '0;
      1: start_value = limit_value - $urandom_range(0, 20);
      2: start_value = rand64();
      default: start_value = limit_value + $urandom_range(1, 20);
    endcase
    ctrl_value = rand64();
    if ($urandom_range(7) != 0) ctrl_value[CtrlEnable] = 1'b1;
    push_item(ModeWrite, RegCompare, limit_value, rand64());
    push_item(ModeWrite, RegCount, start_value, rand64());
    push_item(ModeWrite, RegCtrl, ctrl_value, now_stamp);
    steps = $urandom_range(3, 12);
    repeat (steps) begin
      case ($urandom_range(19))
        0, 1, 2: push_item(ModeRead, 3'($urandom_range(7)), rand64(), rand64());
        3, 4: push_item(ModeWrite, RegStatus, rand64(), rand64());
        5: begin
          ctrl_value = rand64();
          ctrl_value[CtrlEnable] = 1'b1;
          push_item(ModeWrite, RegCtrl, ctrl_value, now_stamp);
        end
        default: begin
          now_stamp = now_stamp + pick_elapsed();
          push_item(ModeTick, 3'($urandom_range(7)), rand64(), now_stamp);
        end
      endcase
    end
  endtask

  task automatic run_random(input int unsigned target);
    logic [ModeW-1:0] mode;
    while (items_sent < target) begin
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(1, 4)) begin
          mode = ($urandom_range(15) == 0) ? ModeNone : 2'($urandom_range(2));
          push_item(mode, 3'($urandom_range(7)), rand64(), rand64());
        end
      end else begin
        run_sequence();
      end
    end
  endtask

  initial begin : stimulus
    int unsigned phase;
    rst_ni = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = CfgHostFreq;
    cfg_ch.data = '0;
    in_ch.valid = 1'b0;
    in_ch.mode = ModeRead;
    in_ch.reg_index = RegCtrl;
    in_ch.write_data = '0;
    in_ch.cycle_stamp = '0;
    send_idle = 34;
    recv_idle = 65;
    items_sent = 0;
    base_freq_set = HostFreqReset;
    virt_freq_set = VirtFreqReset;
    now_stamp = '0;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    run_directed();
    for (phase = 0; phase < 6; phase++) begin
      settle();
      if (phase == 2) begin
        send_idle = 65;
        recv_idle = 34;
      end else if (phase == 4) begin
        send_idle = 0;
        recv_idle = 0;
      end
      case (phase)
        0: begin
          base_freq_set = 64'd1000;
          virt_freq_set = 32'd1;
        end
        1: begin
          base_freq_set = 64'd1;
          virt_freq_set = '1;
        end
        2: begin
          base_freq_set = '1;
          virt_freq_set = '1;
        end
        3: begin
          base_freq_set = '0;
          virt_freq_set = 32'd3;
        end
        4: begin
          base_freq_set = 64'($urandom_range(1, 1000000));
          virt_freq_set = $urandom;
          if (virt_freq_set == '0) virt_freq_set = 32'd1;
        end
        default: begin
          base_freq_set = HostFreqReset;
          virt_freq_set = VirtFreqReset;
        end
      endcase
      write_config(CfgHostFreq, base_freq_set);
      write_config(CfgVirtFreq, {$urandom, virt_freq_set});
      if (phase == 1 || phase == 3) begin
        // The full stamp range as elapsed time gives a quotient wider than 64 bits.
        push_item(ModeWrite, RegCtrl, 64'd1 << CtrlEnable, '0);
        push_item(ModeTick, RegCtrl, '0, '1);
        push_item(ModeRead, RegCount, '0, '0);
        now_stamp = '1;
      end
      run_random(items_sent + 115);
    end
    settle();
    repeat (120) @(posedge clk_i);

    $display("Checked %0d results from %0d items over six frequency settings,",
             checked_count, items_sent);
    $display("with ticks, register accesses and idle patterns on both channels.");
    if (mismatch_count == 0 && pending_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+rtl
rtl/cmt_pkg.sv
rtl/cmt_if.sv
rtl/cmt_div.sv
rtl/compare_match_timer_fractional.sv
rtl/cmt_chk.sv
bench/cmt_timer_checker.sv
bench/tb_compare_match_timer_fractional.sv
